// ===== rtl/core/length_prefixed_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame deframer
// Concurrent checks in simulation; they collapse to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every rising edge of clk, masked while rst is high.
`define LPFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define LPFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LPFD_ASSERT(label, clk, rst, prop, msg)
`define LPFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Package for the length-prefixed frame deframer
// Shared widths, codes, reset values and the record passed front to back.
// ----------------------------------------------------------------------------
package lpfd_pkg;

   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 9;
   localparam int LEN_W    = 16;
   localparam int FRAME_W  = 17;
   localparam int STATUS_W = 2;

   localparam int BUFFER_BYTES_DEF = 512;
   localparam int HEADER_BYTES_DEF = 18;
   localparam int CRC_BYTES_DEF    = 2;
   localparam int QUEUE_DEPTH_DEF  = 4;

   localparam logic [DATA_W-1:0] START_BYTE_RST  = 8'd170;
   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd256;

   // Configuration register indexes.
   localparam logic CSR_START_BYTE  = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // Classification of one result, decided by the front end.
   typedef enum logic [1:0] {
      K_PASS     = 2'd0,
      K_END      = 2'd1,
      K_TOO_LONG = 2'd2,
      K_OVERFLOW = 2'd3
   } kind_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [OFFSET_W-1:0] offset;
      kind_type            kind;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

endpackage

// ===== rtl/core/lpfd_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for the start byte, tracks header and body, classifies every frame byte.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_front
   import lpfd_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int CRC_BYTES    = CRC_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              command,
   input  logic [DATA_W-1:0] in_byte,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [LEN_W-1:0]  csr_data,
   output logic              res_valid,
   output rec_type           res
);

   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    byte_count_ff, byte_count_in;
   logic [FRAME_W-1:0]  frame_total_ff, frame_total_in;
   logic [DATA_W-1:0]   length_low_ff, length_low_in;
   logic [DATA_W-1:0]   start_byte_ff;
   logic [LEN_W-1:0]    max_payload_ff;

   logic [FRAME_W-1:0]  pos_w;
   logic [FRAME_W-1:0]  next_w;
   logic [LEN_W-1:0]    length;
   logic [FRAME_W-1:0]  total;
   logic                is_start;
   logic                pos_over;
   logic                hdr_low;
   logic                hdr_last;
   logic                too_long;
   logic                too_big;
   logic                empty_end;
   logic                body_end;

   // All position compares are made at frame width so that header constants
   // never get folded into a narrow counter.
   assign pos_w     = FRAME_W'(byte_count_ff);
   assign next_w    = pos_w + FRAME_W'(1);
   assign length    = {in_byte, length_low_ff};
   assign total     = FRAME_W'(HEADER_BYTES) + FRAME_W'(length) + FRAME_W'(CRC_BYTES);
   assign is_start  = (in_byte == start_byte_ff);
   assign pos_over  = (pos_w >= FRAME_W'(BUFFER_BYTES));
   assign hdr_low   = (pos_w == FRAME_W'(HEADER_BYTES - 2));
   assign hdr_last  = (next_w == FRAME_W'(HEADER_BYTES));
   assign too_long  = (length > max_payload_ff);
   assign too_big   = (total > FRAME_W'(BUFFER_BYTES));
   assign empty_end = (total == next_w);
   assign body_end  = (frame_total_ff == next_w);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (command) begin
            phase_in = PH_HUNT;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (pos_over) begin
                     phase_in = PH_HUNT;
                  end else if (hdr_last) begin
                     phase_in = (too_long || too_big || empty_end) ? PH_HUNT : PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (pos_over || body_end) begin
                     phase_in = PH_HUNT;
                  end
               end
               default: begin
                  if (is_start) begin
                     phase_in = PH_HEADER;
                  end
               end
            endcase
         end
      end
   end

   // Counters, length capture and the result record.
   always_comb begin
      byte_count_in  = byte_count_ff;
      frame_total_in = frame_total_ff;
      length_low_in  = length_low_ff;
      res_valid      = 1'b0;
      res.data       = in_byte;
      res.offset     = OFFSET_W'(byte_count_ff);
      res.kind       = K_PASS;
      if (accept) begin
         if (command) begin
            byte_count_in  = '0;
            frame_total_in = '0;
            length_low_in  = '0;
         end else if (phase_ff == PH_HEADER || phase_ff == PH_BODY) begin
            res_valid     = 1'b1;
            byte_count_in = byte_count_ff + CNT_W'(1);
            if (pos_over) begin
               res.kind = K_OVERFLOW;
            end else if (phase_ff == PH_BODY) begin
               if (body_end) begin
                  res.kind = K_END;
               end
            end else begin
               if (hdr_low) begin
                  length_low_in = in_byte;
               end
               if (hdr_last) begin
                  frame_total_in = total;
                  if (too_long) begin
                     res.kind = K_TOO_LONG;
                  end else if (too_big) begin
                     res.kind = K_OVERFLOW;
                  end else if (empty_end) begin
                     res.kind = K_END;
                  end
               end
            end
            // Any final byte, good or aborted, sends the parser back to hunting.
            if (res.kind != K_PASS) begin
               byte_count_in  = '0;
               frame_total_in = '0;
               length_low_in  = '0;
            end
         end else if (is_start) begin
            res_valid      = 1'b1;
            res.offset     = '0;
            byte_count_in  = CNT_W'(1);
            frame_total_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         byte_count_ff  <= '0;
         frame_total_ff <= '0;
         length_low_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         frame_total_ff <= frame_total_in;
         length_low_ff  <= length_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_BYTE:  start_byte_ff  <= csr_data[DATA_W-1:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_data;
            default:         start_byte_ff  <= start_byte_ff;
         endcase
      end
   end

   `LPFD_ASSERT(a_cmd_hunts, clock, reset, (accept && command) |=> (phase_ff == PH_HUNT), "reset command did not return to hunting")
   `LPFD_ASSERT(a_final_hunts, clock, reset, (res_valid && res.kind != K_PASS) |=> (phase_ff == PH_HUNT && byte_count_ff == '0), "final byte did not restart the hunt")
   `LPFD_ASSERT(a_hdr_count, clock, reset, (phase_ff == PH_HEADER) |-> (pos_w < FRAME_W'(HEADER_BYTES) && byte_count_ff != '0), "header count out of range")

endmodule

// ===== rtl/core/lpfd_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer result queue
// Small first-in first-out buffer between front end and output stage.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_queue
   import lpfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rec_type         push_rec,
   input  logic            pop,
   output rec_type         head_rec,
   output queue_flags_type flags
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type            mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign flags.full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign flags.empty = (count_ff == '0);
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign head_rec    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   `LPFD_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_W'(QUEUE_DEPTH), "queue count above depth")
   `LPFD_ASSERT(a_push_lands, clock, reset, (do_push && !do_pop) |=> !flags.empty, "pushed item missing from queue")
   `LPFD_ASSERT(a_pop_frees, clock, reset, (do_pop && !do_push) |=> !flags.full, "popped item left queue full")

endmodule

// ===== rtl/core/lpfd_back.sv =====
// ----------------------------------------------------------------------------
// Deframer output stage
// Drains the queue into the result register and decodes flag and status.
// ----------------------------------------------------------------------------
module lpfd_back
   import lpfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rec_type             head_rec,
   input  queue_flags_type     flags,
   output logic                take,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [DATA_W-1:0]   rsp_data_byte,
   output logic [OFFSET_W-1:0] rsp_byte_offset,
   output logic                rsp_frame_last,
   output logic [STATUS_W-1:0] rsp_status
);

   logic                valid_ff, valid_in;
   logic [DATA_W-1:0]   data_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                last_ff, last_in;
   status_type          status_ff, status_in;

   assign take     = !flags.empty && (!valid_ff || rsp_pop);
   assign valid_in = take || (valid_ff && !rsp_pop);

   always_comb begin
      unique case (head_rec.kind)
         K_PASS:     begin last_in = 1'b0; status_in = ST_OK;       end
         K_END:      begin last_in = 1'b1; status_in = ST_OK;       end
         K_TOO_LONG: begin last_in = 1'b1; status_in = ST_TOO_LONG; end
         K_OVERFLOW: begin last_in = 1'b1; status_in = ST_OVERFLOW; end
         default:    begin last_in = 1'b0; status_in = ST_OK;       end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff   <= head_rec.data;
         offset_ff <= head_rec.offset;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_frame_last  = last_ff;
   assign rsp_status      = status_ff;

endmodule

// ===== rtl/core/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Finds frames by start byte and header length, passes out each frame byte.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// req_      in         push / full             command, in_byte
// rsp_      out        empty / pop             data_byte, byte_offset, frame_last, status
// csr_      in         we (no wait)            index, data
//
// One input item is taken every cycle while the result queue is not full; the
// front end decides an item's fate in the cycle it is accepted, so the per-byte
// counter and compare set the rate. A result goes to the rsp_ ports through
// the result queue and then the output register: the edge that accepts its
// item writes it into the queue, and a later one loads the output register.
// Reset is synchronous and active high; it restores the start byte and maximum
// payload registers and returns the parser to hunting. No clearing pass runs.
// req_full rises only with QUEUE_DEPTH results queued behind a stalled output;
// the output register lets the queue drain at one per cycle while rsp_pop is high.
//
// Items that cause no result (reset commands, bytes dropped while hunting)
// leave the queue untouched, so ordering is that of the accepted items.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer
   import lpfd_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int CRC_BYTES    = CRC_BYTES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // Input items.
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_command,
   input  logic [DATA_W-1:0]   req_in_byte,
   // Result items.
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [DATA_W-1:0]   rsp_data_byte,
   output logic [OFFSET_W-1:0] rsp_byte_offset,
   output logic                rsp_frame_last,
   output logic [STATUS_W-1:0] rsp_status,
   // Configuration writes.
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [LEN_W-1:0]    csr_data
);

   logic            accept;
   logic            res_valid;
   rec_type         res;
   rec_type         head_rec;
   queue_flags_type flags;
   logic            take;

   // An item is accepted whenever the queue has room; every accepted item
   // yields at most one result, so room for one is all that is needed.
   assign req_full = flags.full;
   assign accept   = req_push && !flags.full;

   // Front end: hunting, header and body tracking, and classification.
   lpfd_front #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .CRC_BYTES    (CRC_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .in_byte   (req_in_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // The queue lets the front end run on while the consumer stalls.
   lpfd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_rec (res),
      .pop      (take),
      .head_rec (head_rec),
      .flags    (flags)
   );

   // Back end: output register and status decode.
   lpfd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_rec        (head_rec),
      .flags           (flags),
      .take            (take),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== test/tb_length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Testbench for the length-prefixed frame deframer
// Sends byte streams through the push/full side and checks every result popped
// on the empty/pop side against a cycle-free model of the parser, written here.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer;
   import lpfd_pkg::*;

   // Frame geometry as the block is built by default.
   localparam int unsigned BUF_BYTES       = BUFFER_BYTES_DEF;
   localparam int unsigned HDR_BYTES       = HEADER_BYTES_DEF;
   localparam int unsigned CHK_BYTES       = CRC_BYTES_DEF;
   localparam int unsigned MAX_FIT_PAYLOAD = BUF_BYTES - HDR_BYTES - CHK_BYTES;

   // Run control. The directed tests send close to 800 items on their own, so
   // the random phase only tops them up.
   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 20;
   localparam int RANDOM_ITEMS    = 120;
   localparam int PRINT_CAP       = 40;

   // One result item as the block should give it.
   typedef struct {
      logic [DATA_W-1:0]   data;
      logic [OFFSET_W-1:0] offset;
      logic                last;
      status_type          status;
   } frame_byte_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic                req_command;
   logic [DATA_W-1:0]   req_in_byte;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [DATA_W-1:0]   rsp_data_byte;
   logic [OFFSET_W-1:0] rsp_byte_offset;
   logic                rsp_frame_last;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_we;
   logic                csr_index;
   logic [LEN_W-1:0]    csr_data;

   length_prefixed_frame_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_status      (rsp_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Parser state kept alongside the block. The counters are wider than the
   // block's registers so that a count of BUF_BYTES is held exactly.
   phase_type         parse_phase;
   int unsigned       parse_count;
   int unsigned       parse_total;
   logic [DATA_W-1:0] parse_len_low;

   // Register copies, updated when a write goes out.
   logic [DATA_W-1:0] cfg_start_byte;
   logic [LEN_W-1:0]  cfg_max_payload;

   // Results still owed by the block, oldest first.
   frame_byte_type pending_bytes[$];

   int error_count = 0;
   int items_sent  = 0;
   bit no_idle     = 1'b0;

   // The test side asks for a receiver hold-off by bumping hold_requests; the
   // receiver process alone counts the held cycles.
   int hold_requests = 0;
   int holds_taken   = 0;
   int hold_left     = 0;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("mismatch: %s", msg);
      end
   endtask

   function automatic void restart_hunt();
      parse_phase   = PH_HUNT;
      parse_count   = 0;
      parse_total   = 0;
      parse_len_low = '0;
   endfunction

   function automatic void owe_byte(input logic [DATA_W-1:0] b, input int unsigned pos,
                                    input logic last, input status_type st);
      frame_byte_type fb;
      fb.data   = b;
      fb.offset = OFFSET_W'(pos);
      fb.last   = last;
      fb.status = st;
      pending_bytes.push_back(fb);
   endfunction

   // Works out what one accepted item makes the parser give out.
   function automatic void predict_frame_byte(input logic cmd, input logic [DATA_W-1:0] b);
      int unsigned pos;
      int unsigned len;
      if (cmd) begin
         restart_hunt();
         return;
      end
      if (parse_phase != PH_HEADER && parse_phase != PH_BODY) begin
         // Hunting: only the start byte opens a frame, anything else is dropped.
         if (b == cfg_start_byte) begin
            parse_phase = PH_HEADER;
            parse_count = 1;
            parse_total = 0;
            owe_byte(b, 0, 1'b0, ST_OK);
         end
         return;
      end
      pos = parse_count;
      if (pos >= BUF_BYTES) begin
         restart_hunt();
         owe_byte(b, pos, 1'b1, ST_OVERFLOW);
         return;
      end
      parse_count = pos + 1;
      if (parse_phase == PH_HEADER) begin
         if (pos == HDR_BYTES - 2) begin
            parse_len_low = b;
         end
         if (parse_count == HDR_BYTES) begin
            len = {b, parse_len_low};
            if (len > cfg_max_payload) begin
               restart_hunt();
               owe_byte(b, pos, 1'b1, ST_TOO_LONG);
               return;
            end
            parse_total = HDR_BYTES + len + CHK_BYTES;
            if (parse_total > BUF_BYTES) begin
               restart_hunt();
               owe_byte(b, pos, 1'b1, ST_OVERFLOW);
               return;
            end
            parse_phase = PH_BODY;
         end
      end
      if (parse_phase == PH_BODY && parse_count == parse_total) begin
         restart_hunt();
         owe_byte(b, pos, 1'b1, ST_OK);
         return;
      end
      owe_byte(b, pos, 1'b0, ST_OK);
   endfunction

   // Offers one item and returns at the edge where it was taken. The push stays
   // high on return so that back-to-back items need no re-arm.
   task automatic send_item(input logic cmd, input logic [DATA_W-1:0] b);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_command <= cmd;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      predict_frame_byte(cmd, b);
      items_sent++;
   endtask

   // Sends a frame whose length field is len. Only as many bytes go out as the
   // parser will take as frame bytes, or fewer when cut is not negative.
   task automatic send_frame(input logic [LEN_W-1:0] len, input int cut);
      int whole;
      int n;
      logic [DATA_W-1:0] b;
      whole = (len <= cfg_max_payload && len <= MAX_FIT_PAYLOAD) ?
              int'(HDR_BYTES + CHK_BYTES) + int'(len) : int'(HDR_BYTES);
      n = (cut >= 0 && cut < whole) ? cut : whole;
      for (int i = 0; i < n; i++) begin
         if (i == 0) begin
            b = cfg_start_byte;
         end else if (i == int'(HDR_BYTES) - 2) begin
            b = len[7:0];
         end else if (i == int'(HDR_BYTES) - 1) begin
            b = len[15:8];
         end else begin
            b = DATA_W'($urandom_range(255));
         end
         send_item(1'b0, b);
      end
   endtask

   // Stops offering and waits for every owed result, then lets the pipeline
   // settle so that items which gave nothing have left the front end too.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [LEN_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_START_BYTE) begin
         cfg_start_byte = value[DATA_W-1:0];
      end else begin
         cfg_max_payload = value;
      end
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         return LEN_W'($urandom_range(20));
      end else if (r < 80) begin
         return (cfg_max_payload <= 60) ? cfg_max_payload : LEN_W'($urandom_range(20));
      end else if (r < 90) begin
         return (cfg_max_payload != '1) ? cfg_max_payload + 1'b1 : LEN_W'(MAX_FIT_PAYLOAD + 1);
      end
      return LEN_W'($urandom_range(65535, MAX_FIT_PAYLOAD + 1));
   endfunction

   // Receiver: pops at random, honors hold-off requests, and checks each
   // result taken against the oldest one owed.
   always @(posedge clock) begin
      frame_byte_type fb;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_bytes.size() == 0) begin
               report_mismatch($sformatf("result data %0h offset %0d with nothing owed",
                                         rsp_data_byte, rsp_byte_offset));
            end else begin
               fb = pending_bytes.pop_front();
               if (rsp_data_byte !== fb.data || rsp_byte_offset !== fb.offset ||
                   rsp_frame_last !== fb.last || rsp_status !== fb.status) begin
                  report_mismatch($sformatf(
                     "got data %0h off %0d last %0b st %0d, want %0h %0d %0b %0d",
                     rsp_data_byte, rsp_byte_offset, rsp_frame_last, rsp_status,
                     fb.data, fb.offset, fb.last, fb.status));
               end
            end
         end
         if (hold_requests != holds_taken) begin
            holds_taken = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= no_idle || ($urandom_range(99) >= 9);
         end
      end
   end

   // Watchdog: the run is hung when neither side moves an item for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Reset values: a frame at the default start byte, and bytes that the
   // hunting parser must drop.
   task automatic test_defaults();
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h55);
      send_frame(16'd0, -1);
      wait_drained();
   endtask

   // A reset command in the header, in the body and while hunting.
   task automatic test_reset_command();
      send_frame(16'd5, 9);
      send_item(1'b1, 8'hFF);
      send_item(1'b1, 8'h00);
      send_frame(16'd3, 20);
      send_item(1'b1, cfg_start_byte);
      send_frame(16'd1, -1);
      wait_drained();
   endtask

   // Length above the limit. In the second frame the aborting byte equals the
   // start byte and must not open a new frame.
   task automatic test_payload_limit();
      send_frame(cfg_max_payload + 16'd1, -1);
      send_frame({cfg_start_byte, 8'h01}, -1);
      send_item(1'b0, 8'h11);
      write_register(CSR_MAX_PAYLOAD, 16'd0);
      send_frame(16'd0, -1);
      send_frame(16'd1, -1);
      wait_drained();
   endtask

   // Frames that do not fit the buffer, and the largest one that does, which
   // runs the offset up to its top value.
   task automatic test_buffer_limit();
      write_register(CSR_MAX_PAYLOAD, 16'hFFFF);
      send_frame(LEN_W'(MAX_FIT_PAYLOAD + 1), -1);
      send_frame(16'hFFFF, -1);
      send_frame(LEN_W'(MAX_FIT_PAYLOAD), -1);
      write_register(CSR_MAX_PAYLOAD, MAX_PAYLOAD_RST);
   endtask

   task automatic test_start_byte();
      write_register(CSR_START_BYTE, 16'd0);
      send_item(1'b0, START_BYTE_RST);
      send_frame(16'd2, -1);
      write_register(CSR_START_BYTE, 16'd255);
      send_frame(16'd0, -1);
      write_register(CSR_START_BYTE, LEN_W'(START_BYTE_RST));
   endtask

   // The receiver holds off while a frame streams in without gaps, so the
   // result queue fills and the input stalls.
   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_requests++;
      send_frame(16'd20, -1);
      no_idle = 1'b0;
      wait_drained();
   endtask

   // Mostly well-formed frames with random content, with cut frames, noise
   // and reset commands mixed in, under several register settings.
   task automatic test_random_traffic();
      logic [LEN_W-1:0] starts[4];
      logic [LEN_W-1:0] maxes[4];
      int phase_end;
      int r;
      starts = '{LEN_W'(START_BYTE_RST), 16'd0, 16'd255, LEN_W'($urandom_range(255))};
      maxes  = '{MAX_PAYLOAD_RST, 16'd0, 16'hFFFF, LEN_W'($urandom_range(65535))};
      for (int p = 0; p < 4; p++) begin
         write_register(CSR_START_BYTE, starts[p]);
         write_register(CSR_MAX_PAYLOAD, maxes[p]);
         // The third setting runs with both sides always ready.
         no_idle   = (p == 2);
         phase_end = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < phase_end) begin
            r = $urandom_range(99);
            if (r < 65) begin
               send_frame(pick_length(), -1);
            end else if (r < 78) begin
               send_frame(pick_length(), $urandom_range(19, 1));
               if ($urandom_range(1)) begin
                  send_item(1'b1, DATA_W'($urandom_range(255)));
               end
            end else if (r < 90) begin
               repeat ($urandom_range(6, 1)) begin
                  send_item(1'b0, ($urandom_range(9) == 0) ? cfg_start_byte :
                                  DATA_W'($urandom_range(255)));
               end
            end else begin
               send_item(1'b1, DATA_W'($urandom_range(255)));
            end
         end
         no_idle = 1'b0;
      end
      wait_drained();
   endtask

   initial begin
      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_command <= 1'b0;
      req_in_byte <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_START_BYTE;
      csr_data    <= '0;
      cfg_start_byte  = START_BYTE_RST;
      cfg_max_payload = MAX_PAYLOAD_RST;
      restart_hunt();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_reset_command();
      test_payload_limit();
      test_buffer_limit();
      test_start_byte();
      test_backpressure();
      test_random_traffic();

      // Everything is in; wait for the last owed results and a quiet tail.
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_bytes.size()));
      end

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_front.sv
rtl/core/lpfd_queue.sv
rtl/core/lpfd_back.sv
rtl/core/length_prefixed_frame_deframer.sv
test/tb_length_prefixed_frame_deframer.sv
